### src/ptc_pkg.sv
package ptc_pkg;

	localparam int unsigned NUM_CFG = 5;
	localparam int unsigned ADDR_W  = 5;

	localparam logic [2:0] REG_AC1_AC2 = 3'd0;
	localparam logic [2:0] REG_AC3_AC4 = 3'd1;
	localparam logic [2:0] REG_AC5_AC6 = 3'd2;
	localparam logic [2:0] REG_B1_B2   = 3'd3;
	localparam logic [2:0] REG_MC_MD   = 3'd4;

	localparam logic signed [31:0] B6_OFFSET  = 32'sd4000;
	localparam logic [31:0]        X3_OFFSET  = 32'd32768;
	localparam logic [15:0]        B7_SCALE   = 16'd50000;
	localparam logic signed [15:0] P_SQ_COEF  = 16'sd3038;
	localparam logic signed [15:0] P_LIN_COEF = -16'sd7357;
	localparam logic signed [31:0] P_OFFSET   = 32'sd3791;
	localparam logic signed [31:0] P_LIMIT    = 32'sd655360;
	// ceil(2^23 / 10), exact floor(n/10) for n below P_LIMIT
	localparam logic [19:0]        DIV10_MUL  = 20'd838861;

	typedef struct packed {
		logic [15:0] raw_temp;
		logic [15:0] raw_press;
	} in_t;

	typedef struct packed {
		logic signed [15:0] temp_out;
		logic [15:0]        press_out;
		logic               div_error;
	} out_t;

	typedef struct packed {
		logic [15:0]        up;
		logic signed [16:0] x1t;
		logic               neg;
		logic               err;
	} tdiv_tag_t;

	typedef struct packed {
		logic signed [15:0] temp;
		logic               err;
		logic               sel;
	} pdiv_tag_t;

	// signed division by 2^k, truncating toward zero
	function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] x,
			input int unsigned k);
		logic signed [31:0] bias;
		bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
		return (x + bias) >>> k;
	endfunction

endpackage

### src/pressure_temperature_compensation_top.sv
// Pressure and temperature compensation, one reading per request.
// Input channel in_valid/in_ready/in_data carries a raw temperature and a raw
// pressure sample; output channel out_valid/out_ready/out_data returns the
// compensated temperature (0.1 degC times ten), the pressure in 10 Pa units
// and a divide error flag (outputs zero when a divisor was zero).
// Calibration coefficients sit in five 32-bit registers on the APB port at
// byte addresses 0, 4, 8, 12, 16; write them while no request is in flight.
// The pipe is 74 registers deep: two bit-per-stage divider pipelines (27 and
// 32 stages) plus 15 arithmetic stages, the first loaded at the accept edge.
// Throughput: one request per cycle, sustained while out_ready stays high.
// Reset clears the valid bits of every stage and all calibration registers.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops; nothing is lost or repeated. Bubbles
// in the pipe advance freely when the output stage is empty.
module pressure_temperature_compensation_top import ptc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_t               in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_t              out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [31:0] cfg_q [NUM_CFG];
	logic [2:0]  reg_idx;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) cfg_q[i] <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_AC1_AC2: cfg_q[0] <= pwdata;
				REG_AC3_AC4: cfg_q[1] <= pwdata;
				REG_AC5_AC6: cfg_q[2] <= pwdata;
				REG_B1_B2:   cfg_q[3] <= pwdata;
				REG_MC_MD:   cfg_q[4] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_AC1_AC2: prdata = cfg_q[0];
			REG_AC3_AC4: prdata = cfg_q[1];
			REG_AC5_AC6: prdata = cfg_q[2];
			REG_B1_B2:   prdata = cfg_q[3];
			REG_MC_MD:   prdata = cfg_q[4];
			default:     prdata = '0;
		endcase
	end

	// coefficients
	logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic [15:0]        ac4, ac5, ac6;

	assign ac1 = $signed(cfg_q[0][31:16]);
	assign ac2 = $signed(cfg_q[0][15:0]);
	assign ac3 = $signed(cfg_q[1][31:16]);
	assign ac4 = cfg_q[1][15:0];
	assign ac5 = cfg_q[2][31:16];
	assign ac6 = cfg_q[2][15:0];
	assign b1  = $signed(cfg_q[3][31:16]);
	assign b2  = $signed(cfg_q[3][15:0]);
	assign mc  = $signed(cfg_q[4][31:16]);
	assign md  = $signed(cfg_q[4][15:0]);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_s11, v_s12, v_s13, v_s14, v_s15;
	logic vt_out, vp_out;

	// the pipe advances whenever the output stage can move on
	assign en        = !v_s15 || out_ready;
	assign in_ready  = en;
	assign out_valid = v_s15;

	// stage 1: (ut - ac6) * ac5
	logic signed [16:0] d1;
	logic signed [33:0] p1_full;
	logic [15:0]        up_s1;
	logic signed [31:0] p1_s1;

	assign d1      = $signed({1'b0, in_data.raw_temp}) - $signed({1'b0, ac6});
	assign p1_full = d1 * $signed({1'b0, ac5});

	always_ff @(posedge clk) begin
		if (en) begin
			up_s1 <= in_data.raw_press;
			p1_s1 <= p1_full[31:0];
		end
	end

	// stage 2: x1, divisor, dividend
	logic signed [31:0] x1t_w;
	logic signed [16:0] x1t_s2;
	logic signed [17:0] den_s2;
	logic signed [26:0] numt_s2;
	logic [15:0]        up_s2;

	assign x1t_w = sdiv_p2(p1_s1, 15);

	always_ff @(posedge clk) begin
		if (en) begin
			x1t_s2  <= x1t_w[16:0];
			den_s2  <= 18'(x1t_w) + 18'(md);
			numt_s2 <= 27'(mc) <<< 11;
			up_s2   <= up_s1;
		end
	end

	// temperature divider: (mc * 2048) / (x1 + md)
	tdiv_tag_t  tt_in, tt_out;
	logic [26:0] tnum_mag, tq;
	logic [17:0] tden_mag;
	logic [$bits(tdiv_tag_t)-1:0] tt_out_bits;

	assign tnum_mag   = numt_s2[26] ? 27'(-numt_s2) : 27'(numt_s2);
	assign tden_mag   = den_s2[17] ? 18'(-den_s2) : 18'(den_s2);
	assign tt_in.up   = up_s2;
	assign tt_in.x1t  = x1t_s2;
	assign tt_in.neg  = numt_s2[26] ^ den_s2[17];
	assign tt_in.err  = (den_s2 == '0);
	assign tt_out     = tdiv_tag_t'(tt_out_bits);

	ptc_div #(.NW(27), .DW(18), .TW($bits(tdiv_tag_t))) u_tdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.num       (tnum_mag),
		.den       (tden_mag),
		.tag       (tt_in),
		.out_valid (vt_out),
		.quo       (tq),
		.tag_out   (tt_out_bits)
	);

	// stage 3: b5
	logic signed [31:0] x2t;
	logic signed [31:0] b5_s3;
	logic [15:0]        up_s3;
	logic               err_s3;

	assign x2t = tt_out.neg ? -$signed({5'd0, tq}) : $signed({5'd0, tq});

	always_ff @(posedge clk) begin
		if (en) begin
			b5_s3  <= 32'(tt_out.x1t) + x2t;
			up_s3  <= tt_out.up;
			err_s3 <= tt_out.err;
		end
	end

	// stage 4: b6, temperature quotient
	logic signed [31:0] b6_s4, tq_s4;
	logic [15:0]        up_s4;
	logic               err_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			b6_s4  <= b5_s3 - B6_OFFSET;
			tq_s4  <= sdiv_p2(b5_s3 + 32'sd8, 4);
			up_s4  <= up_s3;
			err_s4 <= err_s3;
		end
	end

	// stage 5: products of b6, temperature clamp
	logic signed [63:0] sq_full;
	logic signed [47:0] a2_full, a3_full;
	logic signed [35:0] t10;
	logic signed [15:0] temp_c;
	logic signed [31:0] sqp_s5, a2p_s5, a3p_s5;
	logic signed [15:0] temp_s5;
	logic [15:0]        up_s5;
	logic               err_s5;

	assign sq_full = b6_s4 * b6_s4;
	assign a2_full = b6_s4 * 48'(ac2);
	assign a3_full = b6_s4 * 48'(ac3);
	assign t10     = 36'(tq_s4) * 36'sd10;

	always_comb begin
		priority if (t10 > 36'sd32767) temp_c = 16'sh7fff;
		else if (t10 < -36'sd32768)    temp_c = -16'sh8000;
		else                           temp_c = t10[15:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqp_s5  <= sq_full[31:0];
			a2p_s5  <= a2_full[31:0];
			a3p_s5  <= a3_full[31:0];
			temp_s5 <= temp_c;
			up_s5   <= up_s4;
			err_s5  <= err_s4;
		end
	end

	// stage 6: scaled terms
	logic signed [31:0] sq_s6, x2a_s6, x1c_s6;
	logic signed [15:0] temp_s6;
	logic [15:0]        up_s6;
	logic               err_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s6   <= sdiv_p2(sqp_s5, 12);
			x2a_s6  <= sdiv_p2(a2p_s5, 11);
			x1c_s6  <= sdiv_p2(a3p_s5, 13);
			temp_s6 <= temp_s5;
			up_s6   <= up_s5;
			err_s6  <= err_s5;
		end
	end

	// stage 7: products of sq
	logic signed [47:0] b2sq_full, b1sq_full;
	logic signed [31:0] b2sq_s7, b1sq_s7, x2a_s7, x1c_s7;
	logic signed [15:0] temp_s7;
	logic [15:0]        up_s7;
	logic               err_s7;

	assign b2sq_full = sq_s6 * 48'(b2);
	assign b1sq_full = sq_s6 * 48'(b1);

	always_ff @(posedge clk) begin
		if (en) begin
			b2sq_s7 <= b2sq_full[31:0];
			b1sq_s7 <= b1sq_full[31:0];
			x2a_s7  <= x2a_s6;
			x1c_s7  <= x1c_s6;
			temp_s7 <= temp_s6;
			up_s7   <= up_s6;
			err_s7  <= err_s6;
		end
	end

	// stage 8: b3 and the b4 operand
	logic signed [31:0] x3a, x3b;
	logic signed [31:0] b3_s8, u_s8;
	logic signed [15:0] temp_s8;
	logic [15:0]        up_s8;
	logic               err_s8;

	assign x3a = sdiv_p2(b2sq_s7, 11) + x2a_s7;
	assign x3b = sdiv_p2(x1c_s7 + sdiv_p2(b1sq_s7, 16) + 32'sd2, 2);

	always_ff @(posedge clk) begin
		if (en) begin
			b3_s8   <= sdiv_p2((32'(ac1) <<< 2) + x3a + 32'sd2, 2);
			u_s8    <= x3b + $signed(X3_OFFSET);
			temp_s8 <= temp_s7;
			up_s8   <= up_s7;
			err_s8  <= err_s7;
		end
	end

	// stage 9: ac4 * u, up - b3
	logic [47:0]        b4_full;
	logic [31:0]        b4p_s9, diff_s9;
	logic signed [15:0] temp_s9;
	logic               err_s9;

	assign b4_full = 48'(ac4) * 48'(unsigned'(u_s8));

	always_ff @(posedge clk) begin
		if (en) begin
			b4p_s9  <= b4_full[31:0];
			diff_s9 <= 32'(up_s8) - unsigned'(b3_s8);
			temp_s9 <= temp_s8;
			err_s9  <= err_s8;
		end
	end

	// stage 10: b4, b7
	logic [47:0]        b7_full;
	logic [16:0]        b4_s10;
	logic [31:0]        b7_s10;
	logic signed [15:0] temp_s10;
	logic               err_s10;

	assign b7_full = 48'(diff_s9) * 48'(B7_SCALE);

	always_ff @(posedge clk) begin
		if (en) begin
			b4_s10   <= b4p_s9[31:15];
			b7_s10   <= b7_full[31:0];
			temp_s10 <= temp_s9;
			err_s10  <= err_s9;
		end
	end

	// pressure divider: b7 * 2 / b4, or b7 / b4 doubled for large b7
	pdiv_tag_t   pt_in, pt_out;
	logic [31:0] pnum, pq;
	logic [$bits(pdiv_tag_t)-1:0] pt_out_bits;

	assign pt_in.sel  = b7_s10[31];
	assign pt_in.temp = temp_s10;
	assign pt_in.err  = err_s10 || (b4_s10 == '0);
	assign pnum       = b7_s10[31] ? b7_s10 : {b7_s10[30:0], 1'b0};
	assign pt_out     = pdiv_tag_t'(pt_out_bits);

	ptc_div #(.NW(32), .DW(17), .TW($bits(pdiv_tag_t))) u_pdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s10),
		.num       (pnum),
		.den       (b4_s10),
		.tag       (pt_in),
		.out_valid (vp_out),
		.quo       (pq),
		.tag_out   (pt_out_bits)
	);

	// stage 11: p, (p/256)^2, -7357 * p
	logic signed [31:0] p_w, a_w;
	logic signed [47:0] aa_full, lin_full;
	logic signed [31:0] p_s11, aa_s11, lin_s11;
	logic signed [15:0] temp_s11;
	logic               err_s11;

	assign p_w      = pt_out.sel ? $signed({pq[30:0], 1'b0}) : $signed(pq);
	assign a_w      = sdiv_p2(p_w, 8);
	assign aa_full  = 48'(a_w) * 48'(a_w);
	assign lin_full = 48'(p_w) * 48'(P_LIN_COEF);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s11    <= p_w;
			aa_s11   <= aa_full[31:0];
			lin_s11  <= lin_full[31:0];
			temp_s11 <= pt_out.temp;
			err_s11  <= pt_out.err;
		end
	end

	// stage 12
	logic signed [47:0] sqc_full;
	logic signed [31:0] p_s12, x1m_s12, x2p_s12;
	logic signed [15:0] temp_s12;
	logic               err_s12;

	assign sqc_full = 48'(aa_s11) * 48'(P_SQ_COEF);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s12    <= p_s11;
			x1m_s12  <= sqc_full[31:0];
			x2p_s12  <= sdiv_p2(lin_s11, 16);
			temp_s12 <= temp_s11;
			err_s12  <= err_s11;
		end
	end

	// stage 13: final pressure in Pa
	logic signed [31:0] psum;
	logic signed [31:0] p2_s13;
	logic signed [15:0] temp_s13;
	logic               err_s13;

	assign psum = sdiv_p2(x1m_s12, 16) + x2p_s12 + P_OFFSET;

	always_ff @(posedge clk) begin
		if (en) begin
			p2_s13   <= p_s12 + sdiv_p2(psum, 4);
			temp_s13 <= temp_s12;
			err_s13  <= err_s12;
		end
	end

	// stage 14: divide by ten through the reciprocal, clamp flags
	logic [39:0]        pd_full;
	logic [39:0]        pd_s14;
	logic               neg_s14, big_s14;
	logic signed [15:0] temp_s14;
	logic               err_s14;

	assign pd_full = 40'(p2_s13[19:0]) * 40'(DIV10_MUL);

	always_ff @(posedge clk) begin
		if (en) begin
			pd_s14   <= pd_full;
			neg_s14  <= p2_s13[31];
			big_s14  <= p2_s13 >= P_LIMIT;
			temp_s14 <= temp_s13;
			err_s14  <= err_s13;
		end
	end

	// stage 15: output register
	logic [15:0] press_c;

	always_comb begin
		priority if (neg_s14) press_c = '0;
		else if (big_s14)     press_c = '1;
		else                  press_c = pd_s14[38:23];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.temp_out  <= err_s14 ? '0 : temp_s14;
			out_data.press_out <= err_s14 ? '0 : press_c;
			out_data.div_error <= err_s14;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= vt_out;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= vp_out;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
		end
	end

endmodule

### src/ptc_div.sv
module ptc_div import ptc_pkg::*; #(
	parameter int unsigned NW = 32,
	parameter int unsigned DW = 17,
	parameter int unsigned TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [TW-1:0] tag_out
);

	logic [DW-1:0] rem_s [NW];
	logic [NW-1:0] num_s [NW];
	logic [DW-1:0] den_s [NW];
	logic [TW-1:0] tag_s [NW];
	logic          vld_s [NW];

	logic [DW-1:0] rem_in [NW];
	logic [NW-1:0] num_in [NW];
	logic [DW-1:0] den_in [NW];
	logic [TW-1:0] tag_in [NW];
	logic          vld_in [NW];

	for (genvar g = 0; g < NW; g++) begin : g_stage
		logic [DW:0] trial;
		logic        ge;

		if (g == 0) begin : g_first
			assign rem_in[g] = '0;
			assign num_in[g] = num;
			assign den_in[g] = den;
			assign tag_in[g] = tag;
			assign vld_in[g] = in_valid;
		end else begin : g_next
			assign rem_in[g] = rem_s[g-1];
			assign num_in[g] = num_s[g-1];
			assign den_in[g] = den_s[g-1];
			assign tag_in[g] = tag_s[g-1];
			assign vld_in[g] = vld_s[g-1];
		end

		// one quotient bit per stage, shifted in where dividend bits leave
		assign trial = {rem_in[g], num_in[g][NW-1]};
		assign ge    = trial >= {1'b0, den_in[g]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_in[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= ge ? DW'(trial - {1'b0, den_in[g]}) : trial[DW-1:0];
				num_s[g] <= {num_in[g][NW-2:0], ge};
				den_s[g] <= den_in[g];
				tag_s[g] <= tag_in[g];
			end
		end
	end

	assign out_valid = vld_s[NW-1];
	assign quo       = num_s[NW-1];
	assign tag_out   = tag_s[NW-1];

endmodule
